FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk with synchronous reset rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define APRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/aprq_pkg.sv
// ----------------------------------------------------------------------------
// aprq_pkg
// Shared widths, codes and types of the aging priority ready queue.
// ----------------------------------------------------------------------------
package aprq_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int PID_W    = 16;
  localparam int PRIO_W   = 4;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SCORE_W  = TIME_W + 1;

  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(9);

  // x/10 = (x * RECIP) >> 35, x/5 = (x * RECIP) >> 34, exact for 32-bit x
  localparam logic [TIME_W-1:0] RECIP = 32'hCCCC_CCCD;
  localparam int DIV10_SH = 35;
  localparam int DIV5_SH  = 34;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_SEL = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd3;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] ready;
    logic [TIME_W-1:0] cpu;
  } slot_t;

  typedef struct packed {
    logic             wr_en;
    logic             clr_en;
    logic [IDX_W-1:0] idx;
    slot_t            data;
  } store_cmd_t;

endpackage

FILE: hw/rtl/aging_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// aging_priority_ready_queue
// Ready queue with aging priority: enqueue with checks, select-and-remove best.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    cmd proc_id prio_level arrival_time ready_time
//                                cpu_time now_time
//  out      out_valid/out_ready  status chosen_pid
//
//  Invalid enqueue goes straight to the final step. Enqueue scans all slots,
//  one slot per cycle. Select scans every slot; each occupied slot
//  takes three steps through the one reciprocal multiplier and comparator.
//  Reset clears all slot valid flags together; nothing else to sweep.
//  A held result stalls only the final step; the next transaction is taken
//  once the result is loaded into the output register.
// ----------------------------------------------------------------------------
module aging_priority_ready_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [aprq_pkg::PID_W-1:0]    proc_id,
  input  logic [aprq_pkg::PRIO_W-1:0]   prio_level,
  input  logic [aprq_pkg::TIME_W-1:0]   arrival_time,
  input  logic [aprq_pkg::TIME_W-1:0]   ready_time,
  input  logic [aprq_pkg::TIME_W-1:0]   cpu_time,
  input  logic [aprq_pkg::TIME_W-1:0]   now_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aprq_pkg::STATUS_W-1:0] status,
  output logic [aprq_pkg::PID_W-1:0]    chosen_pid
);
  import aprq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EQ   = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_PEN  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]          state;
  logic [IDX_W-1:0]    idx;
  logic                cmd_q;
  logic                rej;
  logic                dup;
  logic                err;
  logic                have_free;
  logic                have_best;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    best_idx;
  logic [SCORE_W-1:0]  best_score;
  logic [TIME_W-1:0]   best_ready;
  logic [PID_W-1:0]    best_pid;
  logic [TIME_W-1:0]   wait_q;
  slot_t               new_slot;
  logic [TIME_W-1:0]   now_q;

  slot_t               rd;
  logic [DEPTH-1:0]    valid;
  store_cmd_t          store_cmd;
  logic [TIME_W-1:0]   mul_op;
  logic [TIME_W-1:0]   mul_q;
  logic                last;
  logic                fin_go;
  logic                enq_ok;
  logic                sel_ok;
  logic [STATUS_W-1:0] fin_status;
  logic [SCORE_W-1:0]  score;
  logic                better;
  logic                pre_reject;
  logic [IDX_W:0]      fill;

  aprq_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (store_cmd),
    .rd_idx  (idx),
    .rd_data (rd),
    .valid   (valid)
  );

  aprq_recip_mul u_mul (
    .clk      (clk),
    .operand  (mul_op),
    .sel_div5 (state == S_PEN),
    .quot     (mul_q)
  );

  assign mul_op   = (state == S_PEN) ? rd.cpu : now_q - rd.ready;
  assign last     = (idx == IDX_W'(DEPTH - 1));
  assign in_ready = (state == S_IDLE);
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  assign pre_reject = (proc_id == '0) || (prio_level > PRIO_MAX) ||
                      (ready_time < arrival_time);

  assign score = SCORE_W'(rd.prio) - SCORE_W'(wait_q) + SCORE_W'(mul_q);

  assign better = !have_best ||
                  ($signed(score) < $signed(best_score)) ||
                  ((score == best_score) && (rd.ready < best_ready)) ||
                  ((score == best_score) && (rd.ready == best_ready) &&
                   (rd.pid < best_pid));

  assign enq_ok = !rej && !dup && have_free;
  assign sel_ok = !err && have_best;

  assign fill = (IDX_W+1)'($countones(valid));

  always_comb begin
    if (cmd_q == CMD_ENQ) begin
      fin_status = enq_ok ? ST_OK : ST_REJECT;
    end else if (err) begin
      fin_status = ST_ERROR;
    end else if (!have_best) begin
      fin_status = ST_EMPTY;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_comb begin
    store_cmd.wr_en  = fin_go && (cmd_q == CMD_ENQ) && enq_ok;
    store_cmd.clr_en = fin_go && (cmd_q == CMD_SEL) && sel_ok;
    store_cmd.idx    = (cmd_q == CMD_ENQ) ? free_idx : best_idx;
    store_cmd.data   = new_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_SEL) begin
              state <= S_DIFF;
            end else if (pre_reject) begin
              state <= S_FIN;
            end else begin
              state <= S_EQ;
            end
          end
        end
        S_EQ: begin
          if (last) begin
            state <= S_FIN;
          end
        end
        S_DIFF: begin
          if (valid[idx]) begin
            state <= S_PEN;
          end else if (last) begin
            state <= S_FIN;
          end
        end
        S_PEN: begin
          state <= S_CMP;
        end
        S_CMP: begin
          state <= last ? S_FIN : S_DIFF;
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      status     <= fin_status;
      chosen_pid <= (cmd_q == CMD_SEL && sel_ok) ? best_pid : '0;
    end
    case (state)
      S_IDLE: begin
        idx       <= '0;
        cmd_q     <= cmd;
        rej       <= pre_reject;
        dup       <= 1'b0;
        err       <= 1'b0;
        have_free <= 1'b0;
        have_best <= 1'b0;
        now_q     <= now_time;
        new_slot  <= '{pid: proc_id, prio: prio_level, ready: ready_time,
                       cpu: cpu_time};
      end
      S_EQ: begin
        if (valid[idx]) begin
          if (rd.pid == new_slot.pid) begin
            dup <= 1'b1;
          end
        end else if (!have_free) begin
          have_free <= 1'b1;
          free_idx  <= idx;
        end
        idx <= idx + IDX_W'(1);
      end
      S_DIFF: begin
        if (valid[idx]) begin
          if (rd.ready > now_q) begin
            err <= 1'b1;
          end
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
      S_PEN: begin
        wait_q <= mul_q;
      end
      S_CMP: begin
        if (better) begin
          have_best  <= 1'b1;
          best_idx   <= idx;
          best_score <= score;
          best_ready <= rd.ready;
          best_pid   <= rd.pid;
        end
        idx <= idx + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

`include "assert_macros.svh"

  `APRQ_ASSERT_NOW(a_sel_pid_nonzero, store_cmd.clr_en, best_pid != '0, "select without pid")
  `APRQ_ASSERT_NOW(a_fail_pid_zero, out_valid && status != ST_OK, chosen_pid == '0, "stray pid")
  `APRQ_ASSERT_NXT(a_enq_fills, store_cmd.wr_en, fill == $past(fill) + 1'b1, "no slot filled")
  `APRQ_ASSERT_NXT(a_sel_frees, store_cmd.clr_en, fill + 1'b1 == $past(fill), "no slot freed")

endmodule

FILE: hw/rtl/aprq_recip_mul.sv
// ----------------------------------------------------------------------------
// aprq_recip_mul
// Shared reciprocal multiplier: registered quotient of the operand by 10 or 5.
// ----------------------------------------------------------------------------
module aprq_recip_mul (
  input  logic                        clk,
  input  logic [aprq_pkg::TIME_W-1:0] operand,
  input  logic                        sel_div5,
  output logic [aprq_pkg::TIME_W-1:0] quot
);
  import aprq_pkg::*;

  logic [2*TIME_W-1:0] prod;

  assign prod = {{TIME_W{1'b0}}, operand} * {{TIME_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (sel_div5) begin
      quot <= TIME_W'(prod >> DIV5_SH);
    end else begin
      quot <= TIME_W'(prod >> DIV10_SH);
    end
  end

endmodule

FILE: hw/rtl/aprq_slot_store.sv
// ----------------------------------------------------------------------------
// aprq_slot_store
// Process slots: valid flags plus pid, priority, ready and CPU time per slot.
// ----------------------------------------------------------------------------
module aprq_slot_store (
  input  logic                       clk,
  input  logic                       rst,
  input  aprq_pkg::store_cmd_t       cmd,
  input  logic [aprq_pkg::IDX_W-1:0] rd_idx,
  output aprq_pkg::slot_t            rd_data,
  output logic [aprq_pkg::DEPTH-1:0] valid
);
  import aprq_pkg::*;

  slot_t slots [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.wr_en) begin
      valid[cmd.idx] <= 1'b1;
    end else if (cmd.clr_en) begin
      valid[cmd.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      slots[cmd.idx] <= cmd.data;
    end
  end

  assign rd_data = slots[rd_idx];

endmodule
